// ===== design/crf_pkg.sv =====
package crf_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned NUM_WORDS   = 16;
    localparam int unsigned QR_WORDS    = 4;
    localparam int unsigned NUM_LANES   = 4;
    localparam int unsigned LANE_STAGES = 4;

    // role of a word inside a quarter-round group
    localparam int unsigned QA = 0;
    localparam int unsigned QB = 1;
    localparam int unsigned QC = 2;
    localparam int unsigned QD = 3;

    // half selector codes
    localparam logic [1:0] HALF_FULL   = 2'd0;
    localparam logic [1:0] HALF_FIRST  = 2'd1;
    localparam logic [1:0] HALF_SECOND = 2'd2;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [QR_WORDS-1:0] quad_t;
    typedef word_t [NUM_WORDS-1:0] words_t;

    typedef struct packed {
        logic [63:0] state_pair_0;
        logic [63:0] state_pair_1;
        logic [63:0] state_pair_2;
        logic [63:0] state_pair_3;
        logic [63:0] state_pair_4;
        logic [63:0] state_pair_5;
        logic [63:0] state_pair_6;
        logic [63:0] state_pair_7;
        logic        inverse;
        logic        diagonal;
        logic [1:0]  half_select;
    } req_t;

    typedef struct packed {
        logic [63:0] result_pair_0;
        logic [63:0] result_pair_1;
        logic [63:0] result_pair_2;
        logic [63:0] result_pair_3;
        logic [63:0] result_pair_4;
        logic [63:0] result_pair_5;
        logic [63:0] result_pair_6;
        logic [63:0] result_pair_7;
    } rsp_t;

    typedef struct packed {
        logic inverse;
        logic do_first;
        logic do_second;
    } mode_t;

    // word index of each role, per lane
    localparam logic [3:0] GRP_COL [NUM_LANES][QR_WORDS] = '{
        '{4'd0, 4'd4, 4'd8,  4'd12},
        '{4'd1, 4'd5, 4'd9,  4'd13},
        '{4'd2, 4'd6, 4'd10, 4'd14},
        '{4'd3, 4'd7, 4'd11, 4'd15}
    };
    localparam logic [3:0] GRP_DIAG [NUM_LANES][QR_WORDS] = '{
        '{4'd0, 4'd5, 4'd10, 4'd15},
        '{4'd1, 4'd6, 4'd11, 4'd12},
        '{4'd2, 4'd7, 4'd8,  4'd13},
        '{4'd3, 4'd4, 4'd9,  4'd14}
    };

    // rotation used by each lane stage
    localparam int unsigned ROT_FWD [LANE_STAGES] = '{16, 12, 8, 7};
    localparam int unsigned ROT_INV [LANE_STAGES] = '{7, 8, 12, 16};

    function automatic word_t rotl(word_t v, int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic word_t rotr(word_t v, int unsigned n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    // one add/sub step of a quarter round; second_op picks the c/b step
    // (forward) or the d/a step (inverse)
    function automatic quad_t qr_step(quad_t q, logic inv, logic second_op,
                                      int unsigned rot_f, int unsigned rot_i);
        quad_t r;
        r = q;
        if (!inv) begin
            if (!second_op) begin
                r[QA] = q[QA] + q[QB];
                r[QD] = rotl(q[QD] ^ r[QA], rot_f);
            end
            else begin
                r[QC] = q[QC] + q[QD];
                r[QB] = rotl(q[QB] ^ r[QC], rot_f);
            end
        end
        else begin
            if (!second_op) begin
                r[QB] = rotr(q[QB], rot_i) ^ q[QC];
                r[QC] = q[QC] - q[QD];
            end
            else begin
                r[QD] = rotr(q[QD], rot_i) ^ q[QA];
                r[QA] = q[QA] - q[QB];
            end
        end
        return r;
    endfunction

endpackage

// ===== design/chacha_round_fwd_inv.sv =====
// one chacha round (column or diagonal grouping), forward or inverse, on a
// full 16-word state; half_select picks the full quarter round or one half
//
// channels: req (req_valid/req_ready/req) carries the state pairs and mode
// bits; rsp (rsp_valid/rsp_ready/rsp) returns the new state pairs. a request
// is taken on any edge where valid and ready are both high
//
// pipeline: four add/sub stages inside each of the four quarter-round lanes,
// then the output register, which drives rsp and rsp_valid
// throughput: one request per cycle while the output is empty or rsp_ready is high
//
// reset clears the valid bits of every stage and of the output; data
// registers are not reset. when rsp_valid is high and rsp_ready is low the
// whole pipeline holds and req_ready goes low; otherwise req_ready is high
module chacha_round_fwd_inv
    import crf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic                   adv;
    words_t                 w_in;
    mode_t                  mode_in;
    quad_t                  lane_in  [NUM_LANES];
    quad_t                  lane_out [NUM_LANES];
    rsp_t                   merged;
    logic [LANE_STAGES-1:0] stage_valid_reg;
    logic [LANE_STAGES-1:0] diag_reg;
    logic                   out_valid_reg;
    rsp_t                   rsp_reg;

    assign adv       = !out_valid_reg || rsp_ready;
    assign req_ready = adv;
    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    assign w_in = {req.state_pair_7, req.state_pair_6, req.state_pair_5,
                   req.state_pair_4, req.state_pair_3, req.state_pair_2,
                   req.state_pair_1, req.state_pair_0};

    assign mode_in.inverse   = req.inverse;
    assign mode_in.do_first  = req.half_select inside {HALF_FULL, HALF_FIRST};
    assign mode_in.do_second = req.half_select inside {HALF_FULL, HALF_SECOND};

    // gather the four words of each quarter round
    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            for (int j = 0; j < QR_WORDS; j++)
            begin
                lane_in[k][j] = req.diagonal ? w_in[GRP_DIAG[k][j]]
                                             : w_in[GRP_COL[k][j]];
            end
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        crf_lane u_lane (
            .clk     (clk),
            .adv     (adv),
            .q_in    (lane_in[k]),
            .mode_in (mode_in),
            .q_out   (lane_out[k])
        );
    end

    crf_merge u_merge (
        .q        (lane_out),
        .diagonal (diag_reg[LANE_STAGES-1]),
        .rsp      (merged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            stage_valid_reg <= {stage_valid_reg[LANE_STAGES-2:0], req_valid};
            out_valid_reg   <= stage_valid_reg[LANE_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diag_reg <= {diag_reg[LANE_STAGES-2:0], req.diagonal};
            rsp_reg  <= merged;
        end
    end

endmodule

// ===== design/crf_lane.sv =====
module crf_lane
    import crf_pkg::*;
(
    input  logic  clk,
    input  logic  adv,
    input  quad_t q_in,
    input  mode_t mode_in,
    output quad_t q_out
);

    quad_t q_reg    [LANE_STAGES];
    mode_t mode_reg [LANE_STAGES-1];

    for (genvar s = 0; s < LANE_STAGES; s++) begin : g_stage
        quad_t q_src;
        mode_t m_src;
        logic  en;
        quad_t q_next;

        if (s == 0) begin : g_first
            assign q_src = q_in;
            assign m_src = mode_in;
        end
        else begin : g_rest
            assign q_src = q_reg[s-1];
            assign m_src = mode_reg[s-1];
        end

        // inverse runs the 8/7 half first, so its early stages follow do_second
        if (s < LANE_STAGES / 2) begin : g_early
            assign en = m_src.inverse ? m_src.do_second : m_src.do_first;
        end
        else begin : g_late
            assign en = m_src.inverse ? m_src.do_first : m_src.do_second;
        end

        assign q_next = en ? qr_step(q_src, m_src.inverse, 1'(s % 2),
                                     ROT_FWD[s], ROT_INV[s])
                           : q_src;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_reg[s] <= q_next;
            end
        end

        if (s < LANE_STAGES - 1) begin : g_mode
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    mode_reg[s] <= m_src;
                end
            end
        end
    end

    assign q_out = q_reg[LANE_STAGES-1];

endmodule

// ===== design/crf_merge.sv =====
module crf_merge
    import crf_pkg::*;
(
    input  quad_t q    [NUM_LANES],
    input  logic  diagonal,
    output rsp_t  rsp
);

    words_t w_col;
    words_t w_diag;
    words_t w;

    // scatter each lane's four words back to their state positions
    always_comb
    begin
        w_col  = '0;
        w_diag = '0;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            for (int j = 0; j < QR_WORDS; j++)
            begin
                w_col[GRP_COL[k][j]]   = q[k][j];
                w_diag[GRP_DIAG[k][j]] = q[k][j];
            end
        end
        w = diagonal ? w_diag : w_col;

        rsp.result_pair_0 = w[1:0];
        rsp.result_pair_1 = w[3:2];
        rsp.result_pair_2 = w[5:4];
        rsp.result_pair_3 = w[7:6];
        rsp.result_pair_4 = w[9:8];
        rsp.result_pair_5 = w[11:10];
        rsp.result_pair_6 = w[13:12];
        rsp.result_pair_7 = w[15:14];
    end

endmodule

// ===== design/crf_checker.sv =====
module crf_checker
    import crf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // a stalled response keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // a response only goes away after being taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rsp_valid) |-> $past(rsp_ready))
        else $error("response dropped without handshake");

    // a stalled output holds the whole pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request taken while output stalled");

    // an empty output never blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request blocked with empty output");

endmodule

bind chacha_round_fwd_inv crf_checker u_crf_checker (.*);
